/* rtl/lfh_pkg.sv */
package lfh_pkg;

  // Counter geometry.
  localparam int NUM_LETTERS = 26;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = $clog2(NUM_LETTERS);
  localparam int OUT_COUNT_W = 16;

  // Character codes that bound the two letter ranges.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IDX_W-1:0]       idx_t;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic inc_en;  // count the decoded letter
    logic shift;   // move every count one cell toward cell 0
  } cell_ctrl_t;

  typedef enum logic {
    ST_COUNT,
    ST_EMIT
  } lfh_state_t;

endpackage

/* rtl/lfh_cell.sv */
module lfh_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lfh_pkg::cell_ctrl_t ctrl,
  input  logic                hit,       // the current letter belongs to this cell
  input  lfh_pkg::count_t     shift_in,  // count of the next cell up the chain
  output lfh_pkg::count_t     count
);
  import lfh_pkg::*;

  count_t count_r, count_nxt;

  // Shift takes the neighbor's count; otherwise count a hit, saturating.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.shift) begin
      count_nxt = shift_in;
    end else if (ctrl.inc_en && hit && (count_r != COUNT_MAX)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

/* rtl/letter_frequency_histogram.sv */
// A character word is counted at the edge that accepts it. After an end-marked word,
// emission shifts the 26-cell chain one place per cycle toward cell 0 while the output
// is free, until the chain is empty; each nonzero count in cell 0 becomes a result, and a
// string without letters gives a single empty result. Input is held off during emission;
// while counting, the block takes one character word per cycle.
// Reset (synchronous, active low) clears all counters and the output valid flag.
module letter_frequency_histogram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tuser,   // [0] char_valid
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [4:0] letter_index, [20:5] letter_count, [23:21] zero
  output logic        out_tuser,  // [0] letter_present
  output logic        out_tlast   // last_result
);
  import lfh_pkg::*;

  lfh_state_t state_r, state_nxt;
  logic       first_r, first_nxt;
  idx_t       idx_r, idx_nxt;

  logic                   out_valid_r, out_valid_nxt;
  idx_t                   out_idx_r, out_idx_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                   out_present_r, out_present_nxt;
  logic                   out_last_r, out_last_nxt;

  cell_ctrl_t              ctrl;
  logic [NUM_LETTERS-1:0]  hit;
  logic [NUM_LETTERS-1:0]  nz;
  count_t                  cnt [NUM_LETTERS];
  logic                    is_letter;
  logic [7:0]              slot;
  logic                    in_acc;
  logic                    out_free;

  assign in_tready = (state_r == ST_COUNT);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Fold both cases onto a letter slot.
  always_comb begin
    is_letter = 1'b0;
    slot      = '0;
    if (in_tdata inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      is_letter = 1'b1;
      slot      = in_tdata - CHAR_UPPER_A;
    end else if (in_tdata inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
      is_letter = 1'b1;
      slot      = in_tdata - CHAR_LOWER_A;
    end
  end

  // The chain of counter cells; the top cell takes in zeros as it shifts.
  for (genvar i = 0; i < NUM_LETTERS; i++) begin : g_cell
    count_t shift_in;
    assign hit[i] = is_letter && (slot == 8'(i));
    assign nz[i]  = (cnt[i] != '0);
    if (i == NUM_LETTERS - 1) begin : g_top
      assign shift_in = '0;
    end else begin : g_mid
      assign shift_in = cnt[i+1];
    end
    lfh_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .hit      (hit[i]),
      .shift_in (shift_in),
      .count    (cnt[i])
    );
  end

  // Counting accepts words; emission reads cell 0 and shifts until the chain is empty.
  always_comb begin
    state_nxt       = state_r;
    first_nxt       = first_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_idx_nxt     = out_idx_r;
    out_count_nxt   = out_count_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;
    ctrl.inc_en     = 1'b0;
    ctrl.shift      = 1'b0;
    case (state_r)
      ST_COUNT: begin
        ctrl.inc_en = in_acc && in_tuser;
        if (in_acc && in_tlast) begin
          state_nxt = ST_EMIT;
          first_nxt = 1'b1;
          idx_nxt   = '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (nz == '0) begin
            // Chain is empty: done, with a single empty result if nothing was seen.
            if (first_r) begin
              out_valid_nxt   = 1'b1;
              out_idx_nxt     = '0;
              out_count_nxt   = '0;
              out_present_nxt = 1'b0;
              out_last_nxt    = 1'b1;
            end
            state_nxt = ST_COUNT;
          end else begin
            if (nz[0]) begin
              out_valid_nxt   = 1'b1;
              out_idx_nxt     = idx_r;
              out_count_nxt   = OUT_COUNT_W'(cnt[0]);
              out_present_nxt = 1'b1;
              out_last_nxt    = (nz[NUM_LETTERS-1:1] == '0);
            end
            ctrl.shift = 1'b1;
            first_nxt  = 1'b0;
            idx_nxt    = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      first_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload holds while the word waits.
  always_ff @(posedge clk) begin
    out_idx_r     <= out_idx_nxt;
    out_count_r   <= out_count_nxt;
    out_present_r <= out_present_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_idx_r};
  assign out_tuser  = out_present_r;
  assign out_tlast  = out_last_r;

endmodule

/* dv/letter_frequency_histogram_tb.sv */
`timescale 1ns / 100ps

module letter_frequency_histogram_tb;

  import lfh_pkg::*;

  // One result word as the block reports it.
  typedef struct packed {
    idx_t                   idx;
    logic [OUT_COUNT_W-1:0] cnt;
    logic                   present;
    logic                   last;
  } hist_entry_t;

  // One character word, plus a typed expectation for rows of the directed table.
  typedef struct packed {
    logic [7:0]  chr;
    logic        cv;
    logic        eos;
    logic        typed;
    hist_entry_t want;
  } stim_row_t;

  localparam int          DIR_ROWS   = 21;
  localparam int          RAND_WORDS = 200;
  localparam int          HOLD_LEN   = 300;
  localparam hist_entry_t NO_LETTERS = '{idx: '0, cnt: '0, present: 1'b0, last: 1'b1};
  localparam hist_entry_t UNTYPED    = '{idx: '0, cnt: '0, present: 1'b0, last: 1'b0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Predictor state and the queue of results still owed by the block.
  count_t      letter_tally [NUM_LETTERS];
  hist_entry_t fresh_entries [$];
  hist_entry_t entries_due [$];
  int          errors = 0;
  int          words_sent = 0;
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;

  // Directed words: extremes of the character range, both letter cases, the
  // ignored byte, a byte riding on the end mark and a string without letters.
  stim_row_t dir_table [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, NO_LETTERS},
    '{8'h41, 1'b1, 1'b1, 1'b1, '{5'd0, 16'd1, 1'b1, 1'b1}},
    '{8'h7A, 1'b1, 1'b1, 1'b1, '{5'd25, 16'd1, 1'b1, 1'b1}},
    '{8'h61, 1'b0, 1'b1, 1'b1, NO_LETTERS},
    '{8'h40, 1'b1, 1'b1, 1'b1, NO_LETTERS},
    '{8'h5B, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'h60, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'h7B, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'hFF, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'hC1, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'hE1, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'h00, 1'b1, 1'b1, 1'b1, NO_LETTERS},
    '{8'h5A, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'h61, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'h41, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'h7A, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'h4D, 1'b0, 1'b0, 1'b0, UNTYPED},
    '{8'h6D, 1'b1, 1'b1, 1'b0, UNTYPED},
    '{8'h51, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'h71, 1'b1, 1'b0, 1'b0, UNTYPED},
    '{8'hFF, 1'b0, 1'b1, 1'b0, UNTYPED}
  };

  letter_frequency_histogram uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Count one character word and, on the end mark, build the histogram run.
  function automatic void tally_word(logic [7:0] chr, logic cv, logic eos);
    int          slot;
    int          top;
    hist_entry_t e;
    slot = -1;
    top  = -1;
    if (cv) begin
      if (chr >= CHAR_UPPER_A && chr <= CHAR_UPPER_Z) slot = int'(chr - CHAR_UPPER_A);
      else if (chr >= CHAR_LOWER_A && chr <= CHAR_LOWER_Z) slot = int'(chr - CHAR_LOWER_A);
      if (slot >= 0 && letter_tally[slot] != COUNT_MAX) letter_tally[slot]++;
    end
    if (!eos) return;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (letter_tally[i] != '0) top = i;
    end
    if (top < 0) begin
      fresh_entries.push_back(NO_LETTERS);
    end else begin
      for (int i = 0; i <= top; i++) begin
        if (letter_tally[i] != '0) begin
          e.idx     = idx_t'(i);
          e.cnt     = letter_tally[i][OUT_COUNT_W-1:0];
          e.present = 1'b1;
          e.last    = (i == top);
          fresh_entries.push_back(e);
        end
      end
    end
    for (int i = 0; i < NUM_LETTERS; i++) letter_tally[i] = '0;
  endfunction

  // Offer one word after a random gap and record what it should produce.
  task automatic send_word(input stim_row_t row);
    while (!quiet && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= row.chr;
    in_tuser  <= row.cv;
    in_tlast  <= row.eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    tally_word(row.chr, row.cv, row.eos);
    if (row.typed) begin
      fresh_entries.delete();
      entries_due.push_back(row.want);
    end else begin
      while (fresh_entries.size() != 0) entries_due.push_back(fresh_entries.pop_front());
    end
  endtask

  function automatic logic [7:0] any_letter(int code);
    return ($urandom_range(1) != 0) ? CHAR_UPPER_A + 8'(code) : CHAR_LOWER_A + 8'(code);
  endfunction

  // A random string: mostly letters with some noise and a few ignored bytes,
  // closed by an end mark that may carry a byte of its own.
  task automatic send_string(input int len, input bit alphabet);
    stim_row_t row;
    row       = '0;
    row.typed = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (alphabet) row.chr = any_letter(i);
      else if ($urandom_range(9) < 7) row.chr = any_letter($urandom_range(25));
      else row.chr = 8'($urandom_range(255));
      row.cv  = alphabet || ($urandom_range(9) != 0);
      row.eos = 1'b0;
      send_word(row);
    end
    if ($urandom_range(1) != 0) row.chr = any_letter($urandom_range(25));
    else row.chr = 8'($urandom_range(255));
    row.cv  = ($urandom_range(1) != 0);
    row.eos = 1'b1;
    send_word(row);
  endtask

  // Result side: check each accepted word, then pick the next ready value.
  initial begin
    int          hold_left;
    hist_entry_t got;
    hist_entry_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.idx     = out_tdata[4:0];
        got.cnt     = out_tdata[20:5];
        got.present = out_tuser;
        got.last    = out_tlast;
        if (entries_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result idx %0d cnt %0d present %0b last %0b",
                   $time, got.idx, got.cnt, got.present, got.last);
        end else begin
          want = entries_due.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected %0d:%0d:%0b:%0b actual %0d:%0d:%0b:%0b (idx:cnt:pres:last)",
                     $time, want.idx, want.cnt, want.present, want.last,
                     got.idx, got.cnt, got.present, got.last);
          end
        end
      end
      if (hold_request) begin
        hold_left    = HOLD_LEN;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 16);
      end
    end
  end

  // Main sequence: reset, directed table, random strings, then a stretch without idling.
  initial begin
    int        strings;
    int        len;
    strings = 0;
    for (int i = 0; i < NUM_LETTERS; i++) letter_tally[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_word(dir_table[i]);

    while (words_sent < DIR_ROWS + RAND_WORDS) begin
      strings++;
      // Stall the result side once while strings keep coming in.
      if (strings == 8) hold_request = 1'b1;
      if (strings % 10 == 1) begin
        send_string(NUM_LETTERS, 1'b1);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        send_string(len, 1'b0);
      end
    end

    // Back-to-back strings with no idling on either side.
    quiet = 1'b1;
    send_string(NUM_LETTERS, 1'b1);
    send_string(12, 1'b0);
    quiet = 1'b0;
    send_string(3, 1'b0);
    in_tvalid <= 1'b0;

    while (entries_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("letter_frequency_histogram_tb passed");
    end else begin
      $display("letter_frequency_histogram_tb failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("letter_frequency_histogram_tb failed");
    $finish;
  end

endmodule

/* files.f */
rtl/lfh_pkg.sv
rtl/lfh_cell.sv
rtl/letter_frequency_histogram.sv
dv/letter_frequency_histogram_tb.sv
